[rtl/core/tlic_pkg.sv]
// tlic_pkg: constants, row types and tag-row helper functions for the
// two-level inclusive cache tag block
// no dependencies

package tlic_pkg;

    localparam int ADDR_W      = 32;
    localparam int BLK_LOG     = 5;
    localparam int L1_SETS_LOG = 5;
    localparam int L1_WAYS_LOG = 1;
    localparam int L2_SETS_LOG = 7;
    localparam int L2_WAYS_LOG = 2;

    localparam int L1_SETS  = 1 << L1_SETS_LOG;
    localparam int L1_WAYS  = 1 << L1_WAYS_LOG;
    localparam int L2_SETS  = 1 << L2_SETS_LOG;
    localparam int L2_WAYS  = 1 << L2_WAYS_LOG;
    localparam int L1_TAG_W = ADDR_W - BLK_LOG - L1_SETS_LOG;
    localparam int L2_TAG_W = ADDR_W - BLK_LOG - L2_SETS_LOG;

    localparam int CNT_W = 32;
    localparam int SUM_W = 48;
    localparam int CYC_W = 17;

    // one way of a tag row
    typedef struct packed {
        logic                   valid;
        logic                   dirty;
        logic [L1_TAG_W-1:0]    tag;
        logic [L1_WAYS_LOG-1:0] rank;
    } l1_way_t;

    typedef struct packed {
        logic                   valid;
        logic                   dirty;
        logic [L2_TAG_W-1:0]    tag;
        logic [L2_WAYS_LOG-1:0] rank;
    } l2_way_t;

    typedef l1_way_t [L1_WAYS-1:0] l1_row_t;
    typedef l2_way_t [L2_WAYS-1:0] l2_row_t;

    typedef struct packed {
        logic                   hit;
        logic [L1_WAYS_LOG-1:0] way;
    } l1_match_t;

    typedef struct packed {
        logic                   hit;
        logic [L2_WAYS_LOG-1:0] way;
    } l2_match_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD, ST_LK, ST_WB, ST_L2U, ST_WR
    } state_t;

    typedef enum logic [1:0] {
        REG_WRITE_ALLOC = 2'd0,
        REG_L1_LAT      = 2'd1,
        REG_L2_LAT      = 2'd2,
        REG_MEM_LAT     = 2'd3
    } cfg_reg_t;

    // row state after reset: all invalid, way w holds rank w
    function automatic l1_row_t l1_reset_row();
        l1_row_t r;
        for (int i = 0; i < L1_WAYS; i++) begin
            r[i].valid = 1'b0;
            r[i].dirty = 1'b0;
            r[i].tag   = '0;
            r[i].rank  = L1_WAYS_LOG'(i);
        end
        return r;
    endfunction

    function automatic l2_row_t l2_reset_row();
        l2_row_t r;
        for (int i = 0; i < L2_WAYS; i++) begin
            r[i].valid = 1'b0;
            r[i].dirty = 1'b0;
            r[i].tag   = '0;
            r[i].rank  = L2_WAYS_LOG'(i);
        end
        return r;
    endfunction

    // lowest valid way with a matching tag
    function automatic l1_match_t l1_lookup(l1_row_t r, logic [L1_TAG_W-1:0] t);
        l1_match_t m;
        m = '0;
        for (int i = L1_WAYS - 1; i >= 0; i--) begin
            if (r[i].valid && r[i].tag == t) begin
                m.hit = 1'b1;
                m.way = L1_WAYS_LOG'(i);
            end
        end
        return m;
    endfunction

    function automatic l2_match_t l2_lookup(l2_row_t r, logic [L2_TAG_W-1:0] t);
        l2_match_t m;
        m = '0;
        for (int i = L2_WAYS - 1; i >= 0; i--) begin
            if (r[i].valid && r[i].tag == t) begin
                m.hit = 1'b1;
                m.way = L2_WAYS_LOG'(i);
            end
        end
        return m;
    endfunction

    // victim: lowest invalid way, else the least recent one
    function automatic logic [L1_WAYS_LOG-1:0] l1_pick(l1_row_t r);
        logic [L1_WAYS_LOG-1:0] w;
        logic                   found;
        w = '0;
        found = 1'b0;
        for (int i = L1_WAYS - 1; i >= 0; i--) begin
            if (r[i].rank == '0) w = L1_WAYS_LOG'(i);
        end
        for (int i = 0; i < L1_WAYS; i++) begin
            if (!r[i].valid && !found) begin
                w = L1_WAYS_LOG'(i);
                found = 1'b1;
            end
        end
        return w;
    endfunction

    function automatic logic [L2_WAYS_LOG-1:0] l2_pick(l2_row_t r);
        logic [L2_WAYS_LOG-1:0] w;
        logic                   found;
        w = '0;
        found = 1'b0;
        for (int i = L2_WAYS - 1; i >= 0; i--) begin
            if (r[i].rank == '0) w = L2_WAYS_LOG'(i);
        end
        for (int i = 0; i < L2_WAYS; i++) begin
            if (!r[i].valid && !found) begin
                w = L2_WAYS_LOG'(i);
                found = 1'b1;
            end
        end
        return w;
    endfunction

    // make way w most recent, ranks above its old rank drop by one
    function automatic l1_row_t l1_touch(l1_row_t r, logic [L1_WAYS_LOG-1:0] w);
        l1_row_t o;
        o = r;
        for (int i = 0; i < L1_WAYS; i++) begin
            if (r[i].rank > r[w].rank) o[i].rank = r[i].rank - 1'b1;
        end
        o[w].rank = L1_WAYS_LOG'(L1_WAYS - 1);
        return o;
    endfunction

    function automatic l2_row_t l2_touch(l2_row_t r, logic [L2_WAYS_LOG-1:0] w);
        l2_row_t o;
        o = r;
        for (int i = 0; i < L2_WAYS; i++) begin
            if (r[i].rank > r[w].rank) o[i].rank = r[i].rank - 1'b1;
        end
        o[w].rank = L2_WAYS_LOG'(L2_WAYS - 1);
        return o;
    endfunction

endpackage

[rtl/core/tlic_ram.sv]
// tlic_ram: generic single-write, single-read ram with registered read data
// no dependencies

module tlic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/two_level_inclusive_cache_tags.sv]
// two_level_inclusive_cache_tags: top level, tag state of a two-level inclusive
// write-back cache with per-set lru; uses tlic_pkg and tlic_ram
//
// channel  | dir | handshake          | payload
// s_       | in  | s_tvalid/s_tready  | s_tdata: op, address
// m_       | out | m_tvalid/m_tready  | m_tdata: hit flags, cycles, totals
// apb      | in  | psel/penable       | four config registers at 4*i
//
// an access goes through accept, row read, lookup, then on an allocating
// level-one miss an optional write-back of the victim into its l2 row and
// an l2 update, then commit; each tag ram has one read and one write port
// reset is synchronous; row init flags stand in for clearing the tag rams
// a new word is taken only in idle; commit stalls while an old result waits

module two_level_inclusive_cache_tags (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // op[0], address[32:1], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // l1_hit[0], l2_hit[1], went_to_memory[2],
                                    // access_cycles[19:3], access_total[51:20],
                                    // l1_miss_total[83:52], l2_miss_total[115:84],
                                    // cycle_total[163:116], zero pad
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int L1_ROW_W = $bits(tlic_pkg::l1_row_t);
    localparam int L2_ROW_W = $bits(tlic_pkg::l2_row_t);

    // configuration registers
    logic                       wa_reg;
    logic [7:0]                 l1_lat_reg;
    logic [7:0]                 l2_lat_reg;
    logic [15:0]                mem_lat_reg;
    tlic_pkg::cfg_reg_t         cfg_sel;

    // control and item registers
    tlic_pkg::state_t           state_reg, state_next;
    logic                       op_reg, op_next;
    logic [tlic_pkg::ADDR_W-1:0] addr_reg, addr_next;
    tlic_pkg::l1_row_t          l1row_reg, l1row_next;
    tlic_pkg::l2_row_t          l2row_reg, l2row_next;
    logic                       h1_reg, h1_next, h2_reg, h2_next, mem_reg, mem_next;
    logic [tlic_pkg::L2_WAYS_LOG-1:0] w2_reg, w2_next;
    logic [tlic_pkg::L2_SETS_LOG-1:0] wb_set_reg, wb_set_next;
    logic [tlic_pkg::L2_TAG_W-1:0]    wb_tag_reg, wb_tag_next;
    logic                       wr_l1_reg, wr_l1_next, wr_l2_reg, wr_l2_next;
    logic                       l1_init_reg [tlic_pkg::L1_SETS];
    logic                       l2_init_reg [tlic_pkg::L2_SETS];

    // result registers
    logic                       out_valid_reg;
    logic                       o_h1_reg, o_h2_reg, o_mem_reg;
    logic [tlic_pkg::CYC_W-1:0] o_cyc_reg;
    logic [tlic_pkg::CNT_W-1:0] acc_reg, l1m_reg, l2m_reg;
    logic [tlic_pkg::SUM_W-1:0] sum_reg;
    logic                       commit;

    // address fields
    logic [tlic_pkg::L1_SETS_LOG-1:0] set1;
    logic [tlic_pkg::L2_SETS_LOG-1:0] set2;
    logic [tlic_pkg::L1_TAG_W-1:0]    tag1;
    logic [tlic_pkg::L2_TAG_W-1:0]    tag2;
    logic [tlic_pkg::L1_SETS_LOG-1:0] in_set1;
    logic [tlic_pkg::L2_SETS_LOG-1:0] in_set2;

    // ram ports
    logic [L1_ROW_W-1:0]              l1_rdata, l1_wdata;
    logic [L2_ROW_W-1:0]              l2_rdata, l2_wdata;
    logic                             l1_we, l2_we;
    logic [tlic_pkg::L2_SETS_LOG-1:0] l2_waddr, l2_raddr;

    // row helpers
    tlic_pkg::l1_match_t              hit1, bi;
    tlic_pkg::l2_match_t              hit2, wbh;
    logic [tlic_pkg::L1_WAYS_LOG-1:0] v1;
    logic [tlic_pkg::L2_WAYS_LOG-1:0] u2;
    logic [tlic_pkg::ADDR_W-1:0]      vaddr, uaddr;
    logic                             vic_dirty, wb_same;
    tlic_pkg::l1_row_t                l1_hit_row, l1_fill_row, l1_bi_row, l1_tmp;
    tlic_pkg::l2_row_t                l2_dt_row, l2_tmp, wb_src, wb_res, wb_tmp;
    tlic_pkg::l2_row_t                l2_fill_row, l2_hit_row;
    logic [tlic_pkg::CYC_W-1:0]       cyc;
    logic [tlic_pkg::SUM_W:0]         sum_wide;

    assign set1    = addr_reg[tlic_pkg::BLK_LOG +: tlic_pkg::L1_SETS_LOG];
    assign set2    = addr_reg[tlic_pkg::BLK_LOG +: tlic_pkg::L2_SETS_LOG];
    assign tag1    = addr_reg[tlic_pkg::ADDR_W-1 -: tlic_pkg::L1_TAG_W];
    assign tag2    = addr_reg[tlic_pkg::ADDR_W-1 -: tlic_pkg::L2_TAG_W];
    assign in_set1 = s_tdata[1 + tlic_pkg::BLK_LOG +: tlic_pkg::L1_SETS_LOG];
    assign in_set2 = s_tdata[1 + tlic_pkg::BLK_LOG +: tlic_pkg::L2_SETS_LOG];

    // tag rams, one row per set
    tlic_ram #(.WIDTH(L1_ROW_W), .DEPTH(tlic_pkg::L1_SETS)) u_l1_ram (
        .aclk(aclk), .we(l1_we), .waddr(set1), .wdata(l1_wdata),
        .raddr(in_set1), .rdata(l1_rdata)
    );

    tlic_ram #(.WIDTH(L2_ROW_W), .DEPTH(tlic_pkg::L2_SETS)) u_l2_ram (
        .aclk(aclk), .we(l2_we), .waddr(l2_waddr), .wdata(l2_wdata),
        .raddr(l2_raddr), .rdata(l2_rdata)
    );

    // row helper logic
    always_comb begin
        hit1      = tlic_pkg::l1_lookup(l1row_reg, tag1);
        hit2      = tlic_pkg::l2_lookup(l2row_reg, tag2);
        // level-one hit: dirty on write, then touch
        l1_tmp    = l1row_reg;
        if (op_reg) l1_tmp[hit1.way].dirty = 1'b1;
        l1_hit_row = tlic_pkg::l1_touch(l1_tmp, hit1.way);
        // write around on a level-two hit
        l2_tmp    = l2row_reg;
        l2_tmp[hit2.way].dirty = 1'b1;
        l2_dt_row = tlic_pkg::l2_touch(l2_tmp, hit2.way);
        // level-one victim and fill
        v1        = tlic_pkg::l1_pick(l1row_reg);
        vic_dirty = l1row_reg[v1].valid && l1row_reg[v1].dirty;
        vaddr     = {l1row_reg[v1].tag, set1, tlic_pkg::BLK_LOG'(0)};
        l1_tmp    = l1row_reg;
        l1_tmp[v1].valid = 1'b1;
        l1_tmp[v1].dirty = op_reg;
        l1_tmp[v1].tag   = tag1;
        l1_fill_row = tlic_pkg::l1_touch(l1_tmp, v1);
        // victim write-back into its level-two row
        wb_same   = (wb_set_reg == set2);
        wb_src    = wb_same ? l2row_reg :
                    (l2_init_reg[wb_set_reg] ? tlic_pkg::l2_row_t'(l2_rdata)
                                             : tlic_pkg::l2_reset_row());
        wbh       = tlic_pkg::l2_lookup(wb_src, wb_tag_reg);
        wb_tmp    = wb_src;
        wb_tmp[wbh.way].dirty = 1'b1;
        wb_res    = wbh.hit ? tlic_pkg::l2_touch(wb_tmp, wbh.way) : wb_src;
        // level-two hit touch after the level-one fill
        l2_hit_row = tlic_pkg::l2_touch(l2row_reg, w2_reg);
        // level-two victim, back-invalidate, fill
        u2        = tlic_pkg::l2_pick(l2row_reg);
        uaddr     = {l2row_reg[u2].tag, set2, tlic_pkg::BLK_LOG'(0)};
        bi        = tlic_pkg::l1_lookup(l1row_reg,
                        uaddr[tlic_pkg::ADDR_W-1 -: tlic_pkg::L1_TAG_W]);
        l1_bi_row = l1row_reg;
        if (l2row_reg[u2].valid && bi.hit) begin
            l1_bi_row[bi.way].valid = 1'b0;
            l1_bi_row[bi.way].dirty = 1'b0;
        end
        l2_tmp    = l2row_reg;
        l2_tmp[u2].valid = 1'b1;
        l2_tmp[u2].dirty = 1'b0;
        l2_tmp[u2].tag   = tag2;
        l2_fill_row = tlic_pkg::l2_touch(l2_tmp, u2);
    end

    // sequencer: next state and datapath selects
    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        addr_next   = addr_reg;
        l1row_next  = l1row_reg;
        l2row_next  = l2row_reg;
        h1_next     = h1_reg;
        h2_next     = h2_reg;
        mem_next    = mem_reg;
        w2_next     = w2_reg;
        wb_set_next = wb_set_reg;
        wb_tag_next = wb_tag_reg;
        wr_l1_next  = wr_l1_reg;
        wr_l2_next  = wr_l2_reg;
        commit      = 1'b0;
        unique case (state_reg)
            tlic_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tdata[0];
                    addr_next  = s_tdata[tlic_pkg::ADDR_W:1];
                    state_next = tlic_pkg::ST_RD;
                end
            end
            tlic_pkg::ST_RD: begin
                l1row_next = l1_init_reg[set1] ? tlic_pkg::l1_row_t'(l1_rdata)
                                               : tlic_pkg::l1_reset_row();
                l2row_next = l2_init_reg[set2] ? tlic_pkg::l2_row_t'(l2_rdata)
                                               : tlic_pkg::l2_reset_row();
                h1_next    = 1'b0;
                h2_next    = 1'b0;
                mem_next   = 1'b0;
                wr_l1_next = 1'b0;
                wr_l2_next = 1'b0;
                state_next = tlic_pkg::ST_LK;
            end
            tlic_pkg::ST_LK: begin
                w2_next     = hit2.way;
                wb_set_next = vaddr[tlic_pkg::BLK_LOG +: tlic_pkg::L2_SETS_LOG];
                wb_tag_next = vaddr[tlic_pkg::ADDR_W-1 -: tlic_pkg::L2_TAG_W];
                if (hit1.hit) begin
                    h1_next    = 1'b1;
                    l1row_next = l1_hit_row;
                    wr_l1_next = 1'b1;
                    state_next = tlic_pkg::ST_WR;
                end else if (op_reg && !wa_reg) begin
                    // write around
                    h2_next    = hit2.hit;
                    mem_next   = !hit2.hit;
                    l2row_next = l2_dt_row;
                    wr_l2_next = hit2.hit;
                    state_next = tlic_pkg::ST_WR;
                end else begin
                    h2_next    = hit2.hit;
                    mem_next   = !hit2.hit;
                    l1row_next = l1_fill_row;
                    wr_l1_next = 1'b1;
                    wr_l2_next = 1'b1;
                    state_next = vic_dirty ? tlic_pkg::ST_WB : tlic_pkg::ST_L2U;
                end
            end
            tlic_pkg::ST_WB: begin
                if (wb_same) l2row_next = wb_res;
                state_next = tlic_pkg::ST_L2U;
            end
            tlic_pkg::ST_L2U: begin
                if (h2_reg) begin
                    l2row_next = l2_hit_row;
                end else begin
                    l1row_next = l1_bi_row;
                    l2row_next = l2_fill_row;
                end
                state_next = tlic_pkg::ST_WR;
            end
            tlic_pkg::ST_WR: begin
                if (!out_valid_reg || m_tready) begin
                    commit     = 1'b1;
                    state_next = tlic_pkg::ST_IDLE;
                end
            end
            default: state_next = tlic_pkg::ST_IDLE;
        endcase
    end

    // ram write and read address selection
    assign l1_we    = commit && wr_l1_reg;
    assign l1_wdata = l1row_reg;
    assign l2_we    = (commit && wr_l2_reg) || (state_reg == tlic_pkg::ST_WB && !wb_same);
    assign l2_waddr = (state_reg == tlic_pkg::ST_WB) ? wb_set_reg : set2;
    assign l2_wdata = (state_reg == tlic_pkg::ST_WB) ? L2_ROW_W'(wb_res) : L2_ROW_W'(l2row_reg);
    assign l2_raddr = (state_reg == tlic_pkg::ST_IDLE) ? in_set2 : wb_set_next;

    // latency and running sum
    assign cyc = tlic_pkg::CYC_W'(l1_lat_reg)
               + (h1_reg  ? '0 : tlic_pkg::CYC_W'(l2_lat_reg))
               + (mem_reg ? tlic_pkg::CYC_W'(mem_lat_reg) : '0);
    assign sum_wide = {1'b0, sum_reg} + (tlic_pkg::SUM_W + 1)'(cyc);

    // control and item registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlic_pkg::ST_IDLE;
            for (int i = 0; i < tlic_pkg::L1_SETS; i++) l1_init_reg[i] <= 1'b0;
            for (int i = 0; i < tlic_pkg::L2_SETS; i++) l2_init_reg[i] <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (l1_we) l1_init_reg[set1] <= 1'b1;
            if (l2_we) l2_init_reg[l2_waddr] <= 1'b1;
        end
        op_reg     <= op_next;
        addr_reg   <= addr_next;
        l1row_reg  <= l1row_next;
        l2row_reg  <= l2row_next;
        h1_reg     <= h1_next;
        h2_reg     <= h2_next;
        mem_reg    <= mem_next;
        w2_reg     <= w2_next;
        wb_set_reg <= wb_set_next;
        wb_tag_reg <= wb_tag_next;
        wr_l1_reg  <= wr_l1_next;
        wr_l2_reg  <= wr_l2_next;
    end

    // result word and saturating totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            l1m_reg       <= '0;
            l2m_reg       <= '0;
            sum_reg       <= '0;
        end else if (commit) begin
            out_valid_reg <= 1'b1;
            if (acc_reg != '1) acc_reg <= acc_reg + 1'b1;
            if (!h1_reg && l1m_reg != '1) l1m_reg <= l1m_reg + 1'b1;
            if (mem_reg && l2m_reg != '1) l2m_reg <= l2m_reg + 1'b1;
            sum_reg <= sum_wide[tlic_pkg::SUM_W] ? '1 : sum_wide[tlic_pkg::SUM_W-1:0];
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (commit) begin
            o_h1_reg  <= h1_reg;
            o_h2_reg  <= h2_reg;
            o_mem_reg <= mem_reg;
            o_cyc_reg <= cyc;
        end
    end

    // configuration port
    assign cfg_sel = tlic_pkg::cfg_reg_t'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wa_reg      <= 1'b1;
            l1_lat_reg  <= 8'd1;
            l2_lat_reg  <= 8'd5;
            mem_lat_reg <= 16'd100;
        end else if (psel && penable && pwrite) begin
            unique case (cfg_sel)
                tlic_pkg::REG_WRITE_ALLOC: wa_reg      <= pwdata[0];
                tlic_pkg::REG_L1_LAT:      l1_lat_reg  <= pwdata[7:0];
                tlic_pkg::REG_L2_LAT:      l2_lat_reg  <= pwdata[7:0];
                tlic_pkg::REG_MEM_LAT:     mem_lat_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            tlic_pkg::REG_WRITE_ALLOC: prdata = {31'd0, wa_reg};
            tlic_pkg::REG_L1_LAT:      prdata = {24'd0, l1_lat_reg};
            tlic_pkg::REG_L2_LAT:      prdata = {24'd0, l2_lat_reg};
            tlic_pkg::REG_MEM_LAT:     prdata = {16'd0, mem_lat_reg};
            default:                   prdata = '0;
        endcase
    end

    // stream ports
    assign s_tready = (state_reg == tlic_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, sum_reg, l2m_reg, l1m_reg, acc_reg, o_cyc_reg,
                       o_mem_reg, o_h2_reg, o_h1_reg};

endmodule

[rtl/core/tlic_checker.sv]
// tlic_checker: port-level assertions for two_level_inclusive_cache_tags
// bound to the top level; no other dependencies

module tlic_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [167:0] m_tdata
);

    // one access in flight: no new word right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("word accepted while an access is in progress");

    // exactly one of l1 hit, l2 hit, memory
    a_one_source: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[2:0]))
        else $error("result hit flags not one-hot");

    // miss totals never pass the coarser totals
    a_totals_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[115:84] <= m_tdata[83:52] && m_tdata[83:52] <= m_tdata[51:20])
        else $error("miss totals out of order");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind two_level_inclusive_cache_tags tlic_checker u_tlic_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[tb/sv/tb_top.sv]
// tb_top: self-checking testbench for two_level_inclusive_cache_tags
// holds its own cache tag predictor, drives the stream and apb ports and checks every word
// depends on tlic_pkg and the rtl of two_level_inclusive_cache_tags
`timescale 1ns / 100ps

module tb_top;

    localparam int STALL_LIMIT = 20000;
    localparam int L1_LINES = tlic_pkg::L1_SETS * tlic_pkg::L1_WAYS;
    localparam int L2_LINES = tlic_pkg::L2_SETS * tlic_pkg::L2_WAYS;

    typedef struct packed {
        logic [47:0] cycle_total;
        logic [31:0] l2_miss_total;
        logic [31:0] l1_miss_total;
        logic [31:0] access_total;
        logic [16:0] access_cycles;
        logic        went_to_memory;
        logic        l2_hit;
        logic        l1_hit;
    } access_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata = '0;    // op[0], address[32:1], zero pad
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [167:0] m_tdata;         // l1_hit, l2_hit, went_to_memory, access_cycles,
                                   // access_total, l1_miss_total, l2_miss_total,
                                   // cycle_total, zero pad
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    two_level_inclusive_cache_tags i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic                          p1_valid [L1_LINES];
    logic                          p1_dirty [L1_LINES];
    logic [tlic_pkg::L1_TAG_W-1:0] p1_tag   [L1_LINES];
    int                            p1_rank  [L1_LINES];
    logic                          p2_valid [L2_LINES];
    logic                          p2_dirty [L2_LINES];
    logic [tlic_pkg::L2_TAG_W-1:0] p2_tag   [L2_LINES];
    int                            p2_rank  [L2_LINES];
    logic [31:0] n_access, n_l1_miss, n_l2_miss;
    logic [47:0] n_cycles;
    logic        cfg_alloc;
    logic [7:0]  cfg_l1_lat, cfg_l2_lat;
    logic [15:0] cfg_mem_lat;

    access_result_t expected_q[$];
    int  mismatches = 0;
    int  idle_sender = 0, idle_receiver = 0;
    bit  hold_off = 1'b0;
    int  quiet_cycles = 0;

    // per level helpers, level 1 when lv == 1 else level 2
    function automatic int set_base(int lv, logic [31:0] a);
        if (lv == 1)
            return int'((a >> tlic_pkg::BLK_LOG) & (tlic_pkg::L1_SETS - 1)) * tlic_pkg::L1_WAYS;
        return int'((a >> tlic_pkg::BLK_LOG) & (tlic_pkg::L2_SETS - 1)) * tlic_pkg::L2_WAYS;
    endfunction

    function automatic logic [31:0] tag_bits(int lv, logic [31:0] a);
        return lv == 1 ? a >> (tlic_pkg::BLK_LOG + tlic_pkg::L1_SETS_LOG)
                       : a >> (tlic_pkg::BLK_LOG + tlic_pkg::L2_SETS_LOG);
    endfunction

    function automatic int find_line(int lv, logic [31:0] a);
        int b, nw;
        b = set_base(lv, a);
        nw = lv == 1 ? tlic_pkg::L1_WAYS : tlic_pkg::L2_WAYS;
        for (int w = 0; w < nw; w++) begin
            if (lv == 1 && p1_valid[b+w] && p1_tag[b+w] == tag_bits(1, a)) return b + w;
            if (lv == 2 && p2_valid[b+w] && p2_tag[b+w] == tag_bits(2, a)) return b + w;
        end
        return -1;
    endfunction

    function automatic void make_recent(int lv, int line);
        int nw, b, old;
        nw = lv == 1 ? tlic_pkg::L1_WAYS : tlic_pkg::L2_WAYS;
        b = (line / nw) * nw;
        old = lv == 1 ? p1_rank[line] : p2_rank[line];
        for (int w = 0; w < nw; w++) begin
            if (lv == 1 && p1_rank[b+w] > old) p1_rank[b+w]--;
            if (lv == 2 && p2_rank[b+w] > old) p2_rank[b+w]--;
        end
        if (lv == 1) p1_rank[line] = nw - 1;
        else p2_rank[line] = nw - 1;
    endfunction

    function automatic int victim_of(int lv, logic [31:0] a);
        int b, nw, best;
        b = set_base(lv, a);
        nw = lv == 1 ? tlic_pkg::L1_WAYS : tlic_pkg::L2_WAYS;
        best = b;
        for (int w = 0; w < nw; w++)
            if (!(lv == 1 ? p1_valid[b+w] : p2_valid[b+w])) return b + w;
        for (int w = 0; w < nw; w++) begin
            if (lv == 1 && p1_rank[b+w] < p1_rank[best]) best = b + w;
            if (lv == 2 && p2_rank[b+w] < p2_rank[best]) best = b + w;
        end
        return best;
    endfunction

    function automatic logic [31:0] line_address(int lv, int line);
        if (lv == 1)
            return (32'(p1_tag[line]) << (tlic_pkg::BLK_LOG + tlic_pkg::L1_SETS_LOG))
                 | (32'(line / tlic_pkg::L1_WAYS) << tlic_pkg::BLK_LOG);
        return (32'(p2_tag[line]) << (tlic_pkg::BLK_LOG + tlic_pkg::L2_SETS_LOG))
             | (32'(line / tlic_pkg::L2_WAYS) << tlic_pkg::BLK_LOG);
    endfunction

    // bring a block into level one, pushing a dirty victim's state into level two
    function automatic int bring_into_l1(logic [31:0] a);
        int v, e;
        v = victim_of(1, a);
        if (p1_valid[v] && p1_dirty[v]) begin
            e = find_line(2, line_address(1, v));
            if (e >= 0) begin
                p2_dirty[e] = 1'b1;
                make_recent(2, e);
            end
        end
        p1_valid[v] = 1'b1;
        p1_dirty[v] = 1'b0;
        p1_tag[v] = tlic_pkg::L1_TAG_W'(tag_bits(1, a));
        make_recent(1, v);
        return v;
    endfunction

    // fill both levels from memory, back-invalidating the level-two victim
    function automatic int bring_from_memory(logic [31:0] a);
        int v, u, e;
        v = bring_into_l1(a);
        u = victim_of(2, a);
        if (p2_valid[u]) begin
            e = find_line(1, line_address(2, u));
            if (e >= 0) begin
                p1_valid[e] = 1'b0;
                p1_dirty[e] = 1'b0;
            end
        end
        p2_valid[u] = 1'b1;
        p2_dirty[u] = 1'b0;
        p2_tag[u] = tlic_pkg::L2_TAG_W'(tag_bits(2, a));
        make_recent(2, u);
        return v;
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] x);
        return x == '1 ? x : x + 32'd1;
    endfunction

    function automatic void predictor_reset();
        for (int i = 0; i < L1_LINES; i++) begin
            p1_valid[i] = 1'b0; p1_dirty[i] = 1'b0; p1_tag[i] = '0;
            p1_rank[i] = i % tlic_pkg::L1_WAYS;
        end
        for (int i = 0; i < L2_LINES; i++) begin
            p2_valid[i] = 1'b0; p2_dirty[i] = 1'b0; p2_tag[i] = '0;
            p2_rank[i] = i % tlic_pkg::L2_WAYS;
        end
        n_access = '0; n_l1_miss = '0; n_l2_miss = '0; n_cycles = '0;
        cfg_alloc = 1'b1; cfg_l1_lat = 8'd1; cfg_l2_lat = 8'd5; cfg_mem_lat = 16'd100;
    endfunction

    // expected outcome of one access, updates the predictor state
    function automatic access_result_t cache_access(logic wr, logic [31:0] a);
        access_result_t r;
        logic [16:0] cyc;
        logic [48:0] sum;
        int e;
        r = '0;
        cyc = 17'(cfg_l1_lat);
        n_access = sat_inc(n_access);
        e = find_line(1, a);
        if (e >= 0) begin
            r.l1_hit = 1'b1;
            if (wr) p1_dirty[e] = 1'b1;
            make_recent(1, e);
        end else begin
            n_l1_miss = sat_inc(n_l1_miss);
            cyc += 17'(cfg_l2_lat);
            e = find_line(2, a);
            if (e >= 0) begin
                r.l2_hit = 1'b1;
                if (!wr) void'(bring_into_l1(a));
                else if (cfg_alloc) p1_dirty[bring_into_l1(a)] = 1'b1;
                else p2_dirty[e] = 1'b1;
                make_recent(2, e);
            end else begin
                r.went_to_memory = 1'b1;
                n_l2_miss = sat_inc(n_l2_miss);
                cyc += 17'(cfg_mem_lat);
                if (!wr) void'(bring_from_memory(a));
                else if (cfg_alloc) p1_dirty[bring_from_memory(a)] = 1'b1;
            end
        end
        sum = {1'b0, n_cycles} + 49'(cyc);
        n_cycles = sum[48] ? '1 : sum[47:0];
        r.access_cycles = cyc;
        r.access_total = n_access;
        r.l1_miss_total = n_l1_miss;
        r.l2_miss_total = n_l2_miss;
        r.cycle_total = n_cycles;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // send one access word, sender idling at random; valid stays up after the accept
    task automatic send_access(logic wr, logic [31:0] a);
        while (idle_sender > 0 && $urandom_range(99, 0) < idle_sender) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, a, wr};
        expected_q.push_back(cache_access(wr, a));
        do @(posedge aclk); while (!s_tready);
    endtask

    // receiver ready with random stalls
    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_tready <= 1'b0;
        else m_tready <= !(idle_receiver > 0 && $urandom_range(99, 0) < idle_receiver);
    end

    // result checker
    always @(posedge aclk) begin
        access_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[163:0];
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word", 64'(got.access_total), 64'(0));
            end else begin
                want = expected_q.pop_front();
                if (got.l1_hit != want.l1_hit)
                    report_mismatch("l1_hit", 64'(got.l1_hit), 64'(want.l1_hit));
                if (got.l2_hit != want.l2_hit)
                    report_mismatch("l2_hit", 64'(got.l2_hit), 64'(want.l2_hit));
                if (got.went_to_memory != want.went_to_memory)
                    report_mismatch("went_to_memory", 64'(got.went_to_memory),
                                    64'(want.went_to_memory));
                if (got.access_cycles != want.access_cycles)
                    report_mismatch("access_cycles", 64'(got.access_cycles),
                                    64'(want.access_cycles));
                if (got.access_total != want.access_total)
                    report_mismatch("access_total", 64'(got.access_total),
                                    64'(want.access_total));
                if (got.l1_miss_total != want.l1_miss_total)
                    report_mismatch("l1_miss_total", 64'(got.l1_miss_total),
                                    64'(want.l1_miss_total));
                if (got.l2_miss_total != want.l2_miss_total)
                    report_mismatch("l2_miss_total", 64'(got.l2_miss_total),
                                    64'(want.l2_miss_total));
                if (got.cycle_total != want.cycle_total)
                    report_mismatch("cycle_total", 64'(got.cycle_total),
                                    64'(want.cycle_total));
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || expected_q.size() == 0)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("FAIL two_level_inclusive_cache_tags");
            $finish;
        end
    end

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    // one apb write; psel stays up so writes can follow back to back
    task automatic write_reg(tlic_pkg::cfg_reg_t idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 4'(idx) << 2; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            tlic_pkg::REG_WRITE_ALLOC: cfg_alloc = val[0];
            tlic_pkg::REG_L1_LAT:      cfg_l1_lat = val[7:0];
            tlic_pkg::REG_L2_LAT:      cfg_l2_lat = val[7:0];
            default:                   cfg_mem_lat = val[15:0];
        endcase
    endtask

    task automatic set_config(logic alloc, logic [7:0] l1, logic [7:0] l2, logic [15:0] mem);
        drain();
        write_reg(tlic_pkg::REG_WRITE_ALLOC, {31'b0, alloc});
        write_reg(tlic_pkg::REG_L1_LAT, {24'b0, l1});
        write_reg(tlic_pkg::REG_L2_LAT, {24'b0, l2});
        write_reg(tlic_pkg::REG_MEM_LAT, {16'b0, mem});
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // random address from a small working set so that sets conflict and hit
    function automatic logic [31:0] pick_address();
        logic [31:0] a;
        case ($urandom_range(3, 0))
            0: a = $urandom;
            default: begin
                a = $urandom;
                a[12:5] = 8'($urandom_range(3, 0));
                a[31:13] = 19'($urandom_range(7, 0))
                         | ($urandom_range(9, 0) == 0 ? 19'h7ffff : 19'h0);
            end
        endcase
        return a;
    endfunction

    task automatic test_directed();
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b1, 32'hffff_ffff);
        send_access(1'b0, 32'hffff_ffe0);
        // fill one l2 set past its ways so dirty lines get evicted
        for (int i = 0; i < 6; i++) send_access(1'b1, 32'(i) << 12);
        send_access(1'b0, 32'h0000_1000);
        send_access(1'b1, 32'h5555_5555);
        send_access(1'b0, 32'haaaa_aaaa);
    endtask

    task automatic test_write_around();
        set_config(1'b0, 8'd255, 8'd255, 16'hffff);
        send_access(1'b1, 32'h0001_0000);
        send_access(1'b0, 32'h0001_0000);
        send_access(1'b1, 32'h0001_0000);
        send_access(1'b1, 32'h0002_0040);
        send_access(1'b1, 32'h0001_0000);
        set_config(1'b1, 8'd0, 8'd0, 16'd0);
        send_access(1'b0, 32'h0003_0000);
        send_access(1'b1, 32'h0003_0000);
    endtask

    task automatic test_random(int count, int sender_idle, int receiver_idle);
        idle_sender = sender_idle;
        idle_receiver = receiver_idle;
        for (int i = 0; i < count; i++) send_access(1'($urandom), pick_address());
    endtask

    task automatic test_backpressure();
        idle_sender = 0;
        idle_receiver = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 20; i++) send_access(1'($urandom), pick_address());
        join
    endtask

    initial begin
        predictor_reset();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_write_around();
        set_config(1'b0, 8'd3, 8'd17, 16'd1000);
        test_random(450, 6, 73);
        set_config(1'b1, 8'($urandom), 8'($urandom), 16'($urandom));
        test_random(450, 73, 6);
        set_config(1'b1, 8'd1, 8'd5, 16'd100);
        test_random(500, 0, 0);
        test_backpressure();
        drain();
        if (mismatches == 0) $display("PASS two_level_inclusive_cache_tags");
        else $display("FAIL two_level_inclusive_cache_tags");
        $finish;
    end
endmodule

[two_level_inclusive_cache_tags.f]
rtl/core/tlic_pkg.sv
rtl/core/tlic_ram.sv
rtl/core/two_level_inclusive_cache_tags.sv
rtl/core/tlic_checker.sv
tb/sv/tb_top.sv
